// File: src/bia_pkg.sv
`default_nettype none

package bia_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int SHAMT_WIDTH = 5;
    localparam int CODE_WIDTH = 8;

    localparam logic [CODE_WIDTH-1:0] CODE_ALT_LOW  = 8'd20;
    localparam logic [CODE_WIDTH-1:0] CODE_ALT_HIGH = 8'd29;

    localparam logic [CODE_WIDTH-1:0] CODE_ADD  = 8'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_SUB  = 8'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_MUL  = 8'd2;
    localparam logic [CODE_WIDTH-1:0] CODE_DIV  = 8'd3;
    localparam logic [CODE_WIDTH-1:0] CODE_MOD  = 8'd4;
    localparam logic [CODE_WIDTH-1:0] CODE_AND  = 8'd5;
    localparam logic [CODE_WIDTH-1:0] CODE_OR   = 8'd6;
    localparam logic [CODE_WIDTH-1:0] CODE_XOR  = 8'd7;
    localparam logic [CODE_WIDTH-1:0] CODE_SHL  = 8'd8;
    localparam logic [CODE_WIDTH-1:0] CODE_SHR  = 8'd9;
    localparam logic [CODE_WIDTH-1:0] CODE_EQ   = 8'd40;
    localparam logic [CODE_WIDTH-1:0] CODE_NE   = 8'd41;
    localparam logic [CODE_WIDTH-1:0] CODE_LE   = 8'd42;
    localparam logic [CODE_WIDTH-1:0] CODE_LT   = 8'd43;
    localparam logic [CODE_WIDTH-1:0] CODE_GE   = 8'd44;
    localparam logic [CODE_WIDTH-1:0] CODE_GT   = 8'd45;
    localparam logic [CODE_WIDTH-1:0] CODE_LAND = 8'd60;
    localparam logic [CODE_WIDTH-1:0] CODE_LOR  = 8'd61;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2,
        K_MOD    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CODE_WIDTH-1:0]        operation;
        logic signed [WORD_WIDTH-1:0] left_operand;
        logic signed [WORD_WIDTH-1:0] right_operand;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] result_value;
        logic                         bad_operator;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/bytecode_integer_alu.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_data  (operation, operands)
// output    out        o_out_valid / i_out_ready o_out_data (result, bad operator flag)
//
// One transfer is taken every cycle while the output is not stalled. Each result passes
// through a decode stage, the divider, which resolves four quotient bits per stage over
// eight stages, and an output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.

module bytecode_integer_alu (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire bia_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output bia_pkg::t_out_item    o_out_data
);
    import bia_pkg::*;

    localparam int W         = WORD_WIDTH;
    localparam int HALF      = W / 2;
    localparam int UPPER     = W - HALF;
    localparam int STEP_BITS = 4;
    localparam int DSTAGES   = (W + STEP_BITS - 1) / STEP_BITS;

    typedef struct packed {
        t_kind          kind;
        logic           bad;
        logic [W-1:0]   a;
        logic           bzero;
        logic [W-1:0]   simple;
        logic [W-1:0]   mlow;
        logic [UPPER-1:0] mcross;
        logic           na;
        logic           nb;
        logic [W-1:0]   ub;
        logic [W-1:0]   rem;
        logic [W-1:0]   q;
    } t_pipe;

    logic             en;
    logic [DSTAGES:0] r_valid;
    t_pipe            r_pipe [DSTAGES+1];
    t_pipe            n_dec;
    t_pipe            n_pipe [DSTAGES];
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [CODE_WIDTH-1:0] code;
        logic [W-1:0]          a;
        logic [W-1:0]          b;
        logic [SHAMT_WIDTH-1:0] amt;
        logic [W-1:0]          prod_ll;
        logic [UPPER-1:0]      cross_hl;
        logic [UPPER-1:0]      cross_lh;
        code = i_in_data.operation;
        a    = i_in_data.left_operand;
        b    = i_in_data.right_operand;
        amt  = b[SHAMT_WIDTH-1:0];
        if (code >= CODE_ALT_LOW && code <= CODE_ALT_HIGH) begin
            code = code - CODE_ALT_LOW;
        end
        n_dec        = '0;
        n_dec.kind   = K_SIMPLE;
        n_dec.a      = a;
        n_dec.bzero  = (b == '0);
        n_dec.na     = a[W-1];
        n_dec.nb     = b[W-1];
        n_dec.ub     = b[W-1] ? (W)'(-b) : b;
        n_dec.q      = a[W-1] ? (W)'(-a) : a;
        n_dec.rem    = '0;
        prod_ll  = (W)'(a[HALF-1:0] * b[HALF-1:0]);
        cross_hl = (UPPER)'(a[W-1:HALF] * b[UPPER-1:0]);
        cross_lh = (UPPER)'(a[UPPER-1:0] * b[W-1:HALF]);
        n_dec.mlow   = prod_ll;
        n_dec.mcross = cross_hl + cross_lh;
        unique case (code)
            CODE_ADD:  n_dec.simple = a + b;
            CODE_SUB:  n_dec.simple = a - b;
            CODE_MUL:  n_dec.kind = K_MUL;
            CODE_DIV:  n_dec.kind = K_DIV;
            CODE_MOD:  n_dec.kind = K_MOD;
            CODE_AND:  n_dec.simple = a & b;
            CODE_OR:   n_dec.simple = a | b;
            CODE_XOR:  n_dec.simple = a ^ b;
            CODE_SHL:  n_dec.simple = a << amt;
            CODE_SHR:  n_dec.simple = $signed(a) >>> amt;
            CODE_EQ:   n_dec.simple = (W)'(a == b);
            CODE_NE:   n_dec.simple = (W)'(a != b);
            CODE_LE:   n_dec.simple = (W)'($signed(a) <= $signed(b));
            CODE_LT:   n_dec.simple = (W)'($signed(a) < $signed(b));
            CODE_GE:   n_dec.simple = (W)'($signed(a) >= $signed(b));
            CODE_GT:   n_dec.simple = (W)'($signed(a) > $signed(b));
            CODE_LAND: n_dec.simple = (W)'(a != '0 && b != '0);
            CODE_LOR:  n_dec.simple = (W)'(a != '0 || b != '0);
            default:   n_dec.bad = 1'b1;
        endcase
    end

    always_comb begin
        t_pipe        p;
        logic [W-1:0] trial;
        for (int s = 0; s < DSTAGES; s++) begin
            p = r_pipe[s];
            trial = '0;
            if (s == 0) begin
                p.mlow = p.mlow + {p.mcross, {HALF{1'b0}}};
            end
            for (int j = 0; j < STEP_BITS; j++) begin
                if (s * STEP_BITS + j < W) begin
                    trial = {p.rem[W-2:0], p.q[W-1]};
                    p.q   = {p.q[W-2:0], 1'b0};
                    if (trial >= p.ub) begin
                        trial  = trial - p.ub;
                        p.q[0] = 1'b1;
                    end
                    p.rem = trial;
                end
            end
            n_pipe[s] = p;
        end
    end

    always_comb begin
        t_pipe p;
        p = r_pipe[DSTAGES];
        n_out.bad_operator = p.bad;
        case (p.kind)
            K_MUL:   n_out.result_value = p.mlow;
            K_DIV:   n_out.result_value = p.bzero ? p.a : ((p.na ^ p.nb) ? -p.q : p.q);
            K_MOD:   n_out.result_value = p.bzero ? p.a : (p.na ? -p.rem : p.rem);
            default: n_out.result_value = p.simple;
        endcase
        if (p.bad) begin
            n_out.result_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid     <= {r_valid[DSTAGES-1:0], i_in_valid};
            r_out_valid <= r_valid[DSTAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pipe[0] <= n_dec;
            for (int k = 0; k < DSTAGES; k++) begin
                r_pipe[k+1] <= n_pipe[k];
            end
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bia_pkg::*;

    localparam int LATENCY = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_out_item expected_results[$];
    int error_count = 0;
    bit hold_output = 1'b0;
    bit stall_enable = 1'b0;

    bytecode_integer_alu DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [WORD_WIDTH-1:0] shift_result(
        logic [WORD_WIDTH-1:0] a, logic [WORD_WIDTH-1:0] b, bit right);
        logic [SHAMT_WIDTH-1:0] amt;
        amt = b[SHAMT_WIDTH-1:0];
        if (right) begin
            return $signed(a) >>> amt;
        end
        return a << amt;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] quotient_or_rem(
        logic [WORD_WIDTH-1:0] a, logic [WORD_WIDTH-1:0] b, bit want_rem);
        logic [WORD_WIDTH-1:0] ua;
        logic [WORD_WIDTH-1:0] ub;
        logic [WORD_WIDTH-1:0] r;
        if (b == '0) begin
            return a;
        end
        ua = a[WORD_WIDTH-1] ? -a : a;
        ub = b[WORD_WIDTH-1] ? -b : b;
        if (want_rem) begin
            r = ua % ub;
            return a[WORD_WIDTH-1] ? -r : r;
        end
        r = ua / ub;
        return (a[WORD_WIDTH-1] != b[WORD_WIDTH-1]) ? -r : r;
    endfunction

    function automatic t_out_item alu_result(t_in_item item);
        t_out_item res;
        logic [CODE_WIDTH-1:0] op;
        logic signed [WORD_WIDTH-1:0] a;
        logic signed [WORD_WIDTH-1:0] b;
        a = item.left_operand;
        b = item.right_operand;
        op = item.operation;
        if (op >= CODE_ALT_LOW && op <= CODE_ALT_HIGH) begin
            op = op - CODE_ALT_LOW;
        end
        res.bad_operator = 1'b0;
        res.result_value = '0;
        case (op)
            CODE_ADD: res.result_value = a + b;
            CODE_SUB: res.result_value = a - b;
            CODE_MUL: res.result_value = a * b;
            CODE_DIV: res.result_value = quotient_or_rem(a, b, 1'b0);
            CODE_MOD: res.result_value = quotient_or_rem(a, b, 1'b1);
            CODE_AND: res.result_value = a & b;
            CODE_OR: res.result_value = a | b;
            CODE_XOR: res.result_value = a ^ b;
            CODE_SHL: res.result_value = shift_result(a, b, 1'b0);
            CODE_SHR: res.result_value = shift_result(a, b, 1'b1);
            CODE_EQ: res.result_value = WORD_WIDTH'(a == b);
            CODE_NE: res.result_value = WORD_WIDTH'(a != b);
            CODE_LE: res.result_value = WORD_WIDTH'(a <= b);
            CODE_LT: res.result_value = WORD_WIDTH'(a < b);
            CODE_GE: res.result_value = WORD_WIDTH'(a >= b);
            CODE_GT: res.result_value = WORD_WIDTH'(a > b);
            CODE_LAND: res.result_value = WORD_WIDTH'(a != 0 && b != 0);
            CODE_LOR: res.result_value = WORD_WIDTH'(a != 0 || b != 0);
            default: begin
                res.bad_operator = 1'b1;
            end
        endcase
        return res;
    endfunction

    function automatic logic [CODE_WIDTH-1:0] pick_code();
        logic [CODE_WIDTH-1:0] codes[18];
        codes = '{CODE_ADD, CODE_SUB, CODE_MUL, CODE_DIV, CODE_MOD, CODE_AND, CODE_OR,
                  CODE_XOR, CODE_SHL, CODE_SHR, CODE_EQ, CODE_NE, CODE_LE, CODE_LT,
                  CODE_GE, CODE_GT, CODE_LAND, CODE_LOR};
        case ($urandom_range(9))
            0: return CODE_WIDTH'($urandom_range(255));
            1: return codes[$urandom_range(9)] + CODE_ALT_LOW;
            default: return codes[$urandom_range(17)];
        endcase
    endfunction

    function automatic logic [WORD_WIDTH-1:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return WORD_WIDTH'($urandom_range(3));
            4: return WORD_WIDTH'($urandom_range(40) - 20);
            default: return WORD_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [CODE_WIDTH-1:0] op, logic [WORD_WIDTH-1:0] a,
                             logic [WORD_WIDTH-1:0] b);
        t_in_item item;
        item.operation = op;
        item.left_operand = a;
        item.right_operand = b;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(alu_result(item));
    endtask

    task automatic idle_input(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [CODE_WIDTH-1:0] op;
        send_item(CODE_ADD, 32'h7FFF_FFFF, 32'd1);
        send_item(CODE_SUB, 32'h8000_0000, 32'd1);
        send_item(CODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(CODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(CODE_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(CODE_DIV, 32'hFFFF_FFF9, 32'd0);
        send_item(CODE_MOD, 32'd7, 32'd0);
        send_item(CODE_DIV, 32'hFFFF_FFF9, 32'd2);
        send_item(CODE_MOD, 32'hFFFF_FFF9, 32'd2);
        send_item(CODE_AND, 32'hFFFF_FFFF, 32'h5555_AAAA);
        send_item(CODE_OR, 32'd0, 32'h8000_0001);
        send_item(CODE_XOR, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        send_item(CODE_SHL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CODE_SHR, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(CODE_SHR, 32'h4000_0000, 32'd32);
        send_item(CODE_EQ, 32'h8000_0000, 32'h8000_0000);
        send_item(CODE_NE, 32'd1, 32'd2);
        send_item(CODE_LE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(CODE_LT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(CODE_GE, 32'd5, 32'd5);
        send_item(CODE_GT, 32'hFFFF_FFFF, 32'd0);
        send_item(CODE_LAND, 32'd0, 32'd3);
        send_item(CODE_LOR, 32'd0, 32'h8000_0000);
        send_item(8'hFF, 32'h1234_5678, 32'd1);
        op = CODE_SHR + CODE_ALT_LOW;
        send_item(op, 32'hFFFF_0000, 32'd4);
        wait_drained();
    endtask

    task automatic test_random(int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(1) == 1) begin
                    idle_input($urandom_range(1, 6));
                end
            end
            burst--;
            send_item(pick_code(), pick_operand(), pick_operand());
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                repeat (100) @(posedge i_clk);
                hold_output = 1'b0;
            end
            test_random(60);
        join
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_output) begin
            i_out_ready <= 1'b0;
        end else if (stall_enable) begin
            i_out_ready <= ($urandom_range(3) != 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            repeat ($urandom_range(50, 200)) @(posedge i_clk);
            stall_enable = ~stall_enable;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transfer, actual %h", $time, o_out_data);
                error_count++;
            end else begin
                if (o_out_data.result_value !== expected_results[0].result_value) begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             expected_results[0].result_value, o_out_data.result_value);
                    error_count++;
                end
                if (o_out_data.bad_operator !== expected_results[0].bad_operator) begin
                    $display("%0t: bad_operator expected %b actual %b", $time,
                             expected_results[0].bad_operator, o_out_data.bad_operator);
                    error_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(900);
        wait_drained();
        test_backpressure();
        test_random(900);
        idle_input(1);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 3) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: bytecode_integer_alu.f
src/bia_pkg.sv
src/bytecode_integer_alu.sv
sim/tb_top.sv
